[rtl/first_fit_fragment_allocator_macros.svh]
// assertion helpers for the first-fit fragment allocator
`ifndef FIRST_FIT_FRAGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FRAGMENT_ALLOCATOR_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define FFFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fffa assertion failed");

// next-cycle implication
`define FFFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fffa assertion failed");

`else

`define FFFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FFFA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/fffa_pkg.sv]
package fffa_pkg;

  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 8;

  localparam int MAX_FRAGMENTS_DEF = 64;
  localparam int ADDR_BITS_DEF     = 32;

  localparam logic [DATA_W-1:0] BASE_ADDRESS_RST = 32'h0010_0000;
  localparam logic [DATA_W-1:0] POOL_SIZE_RST    = 32'h0010_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE    = 8'd1;

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // request context broadcast to every cell during a scan
  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] base;
  } req_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              live;
    logic              found;
    logic              busy;
    logic [DATA_W-1:0] len;
    logic [DATA_W-1:0] addr;
  } tok_t;

  // append write broadcast, target picked by index
  typedef struct packed {
    logic              en;
    logic [DATA_W-1:0] off;
    logic [DATA_W-1:0] len;
  } wr_t;

endpackage

[rtl/fffa_req_if.sv]
interface fffa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [fffa_pkg::DATA_W-1:0] request_size;
  logic [fffa_pkg::DATA_W-1:0] address;

  modport source (output valid, output mode, output request_size, output address,
                  input ready);
  modport sink (input valid, input mode, input request_size, input address,
                output ready);
endinterface

[rtl/fffa_res_if.sv]
interface fffa_res_if;
  logic                          valid;
  logic                          ready;
  logic [fffa_pkg::DATA_W-1:0]   granted_address;
  logic [fffa_pkg::STATUS_W-1:0] status;
  logic [fffa_pkg::DATA_W-1:0]   used_bytes;
  logic [fffa_pkg::DATA_W-1:0]   free_bytes;

  modport source (output valid, output granted_address, output status,
                  output used_bytes, output free_bytes, input ready);
  modport sink (input valid, input granted_address, input status,
                input used_bytes, input free_bytes, output ready);
endinterface

[rtl/fffa_cfg_if.sv]
interface fffa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fffa_pkg::CFG_IDX_W-1:0] index;
  logic [fffa_pkg::DATA_W-1:0]    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/fffa_cell.sv]
module fffa_cell #(
  parameter int                          MAX_FRAGMENTS = fffa_pkg::MAX_FRAGMENTS_DEF,
  parameter int                          IDX           = 0,
  parameter logic [fffa_pkg::DATA_W-1:0] ADDR_MASK     = '1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fffa_pkg::req_t                   req_i,
  input  fffa_pkg::wr_t                    wr_i,
  input  logic [$clog2(MAX_FRAGMENTS)-1:0] wr_idx_i,
  input  logic [$clog2(MAX_FRAGMENTS+1)-1:0] count_i,
  input  fffa_pkg::tok_t                   tok_i,
  output fffa_pkg::tok_t                   tok_o
);

  localparam int IW = $clog2(MAX_FRAGMENTS);
  localparam int CW = $clog2(MAX_FRAGMENTS+1);

  logic [fffa_pkg::DATA_W-1:0] off_r;
  logic [fffa_pkg::DATA_W-1:0] len_r;
  logic                        busy_r;
  logic                        busy_nxt;
  fffa_pkg::tok_t              tok_r;
  fffa_pkg::tok_t              tok_nxt;

  logic [fffa_pkg::DATA_W-1:0] frag_addr;
  logic                        entry_live;
  logic                        match;
  logic                        hit;
  logic                        wr_here;

  assign frag_addr  = (req_i.base + off_r) & ADDR_MASK;
  assign entry_live = (CW'(IDX) < count_i);
  assign match      = (req_i.mode == fffa_pkg::MODE_FREE) ? (frag_addr == req_i.addr)
                                                          : (!busy_r && (len_r >= req_i.size));
  assign hit        = tok_i.live && !tok_i.found && entry_live && match;
  assign wr_here    = wr_i.en && (wr_idx_i == IW'(IDX));

  always_comb begin
    tok_nxt  = tok_i;
    busy_nxt = busy_r;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.busy  = busy_r;
      tok_nxt.len   = len_r;
      tok_nxt.addr  = frag_addr;
      busy_nxt      = (req_i.mode == fffa_pkg::MODE_ALLOC);
    end
    if (wr_here) begin
      busy_nxt = 1'b1;
    end
  end

  // entry payload, meaningful only below the fill count
  always_ff @(posedge clk) begin
    busy_r <= busy_nxt;
    if (wr_here) begin
      off_r <= wr_i.off;
      len_r <= wr_i.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

[rtl/first_fit_fragment_allocator.sv]
// First-fit fragment allocator. Each alloc or free request walks a search
// token down a row of MAX_FRAGMENTS cells, one cell per clock, each cell
// holding one fragment (offset, length, busy mark). The first live cell that
// fits (free and long enough for alloc, exact start address for free) claims
// the token and updates its own busy mark; an alloc nobody claims appends a
// new fragment at the pool's append point when the table and pool have room.
// One request is in flight at a time: its result waits for the token's walk
// through the whole cell row, unless it is a zero-size alloc or a null free,
// which skips the scan. The next request is taken as soon as the result is
// registered, even if it has not yet been collected. Configuration writes
// (index 0 base_address, index 1 pool_size) are always taken and should only
// be issued while no request is in flight.
`include "first_fit_fragment_allocator_macros.svh"

module first_fit_fragment_allocator #(
  parameter int MAX_FRAGMENTS = fffa_pkg::MAX_FRAGMENTS_DEF,
  parameter int ADDR_BITS     = fffa_pkg::ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  fffa_req_if.sink   in_chan,
  fffa_res_if.source out_chan,
  fffa_cfg_if.sink   cfg_chan
);

  localparam int IW = $clog2(MAX_FRAGMENTS);
  localparam int CW = $clog2(MAX_FRAGMENTS+1);
  localparam int DW = fffa_pkg::DATA_W;

  // fragment addresses wrap to ADDR_BITS, then to the 32-bit result field
  localparam logic [DW-1:0] ADDR_MASK =
    (ADDR_BITS >= DW) ? {DW{1'b1}} : ((DW'(1) << ADDR_BITS) - DW'(1));

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  // configuration registers
  logic [DW-1:0] base_r;
  logic [DW-1:0] pool_r;

  // pool bookkeeping
  logic [CW-1:0] count_r, count_nxt;
  logic [DW-1:0] append_r, append_nxt;
  logic [DW-1:0] bytes_r, bytes_nxt;

  // request held for the duration of the scan
  logic          mode_r;
  logic [DW-1:0] size_r;
  logic [DW-1:0] addr_r;
  logic          early_r;      // zero size or null address, no scan
  logic          launch_r;     // token enters the first cell
  fffa_pkg::tok_t res_tok_r;   // token as it left the last cell

  // outcome of the update step, held for the emit step
  logic [DW-1:0]                 gaddr_r, gaddr_nxt;
  logic [fffa_pkg::STATUS_W-1:0] status_r, status_nxt;

  // output register
  logic                          out_valid_r;
  logic [DW-1:0]                 out_gaddr_r;
  logic [fffa_pkg::STATUS_W-1:0] out_status_r;
  logic [DW-1:0]                 out_used_r;
  logic [DW-1:0]                 out_free_r;

  // chain plumbing
  fffa_pkg::req_t req;
  fffa_pkg::wr_t  wr;
  fffa_pkg::tok_t tok_w [MAX_FRAGMENTS+1];

  logic in_acc;
  logic out_load;
  logic scan_done;
  logic req_bad;
  logic fits_pool;
  logic [DW:0] append_end;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // nothing useful to search for on a zero-size alloc or a null free
  assign req_bad = (in_chan.mode == fffa_pkg::MODE_ALLOC) ? (in_chan.request_size == '0)
                                                          : (in_chan.address == '0);

  assign scan_done = tok_w[MAX_FRAGMENTS].live;

  assign req.mode = mode_r;
  assign req.size = size_r;
  assign req.addr = addr_r;
  assign req.base = base_r;

  always_comb begin
    tok_w[0]      = '0;
    tok_w[0].live = launch_r;
  end

  // ---------------------------------------------------------------------------
  // the cell row
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < MAX_FRAGMENTS; g++) begin : g_cell
    fffa_cell #(
      .MAX_FRAGMENTS (MAX_FRAGMENTS),
      .IDX           (g),
      .ADDR_MASK     (ADDR_MASK)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .req_i    (req),
      .wr_i     (wr),
      .wr_idx_i (count_r[IW-1:0]),
      .count_i  (count_r),
      .tok_i    (tok_w[g]),
      .tok_o    (tok_w[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // update step: settle the request against the token and the pool counters
  // ---------------------------------------------------------------------------
  assign append_end = {1'b0, append_r} + {1'b0, size_r};
  assign fits_pool  = (append_end <= {1'b0, pool_r});

  always_comb begin
    count_nxt  = count_r;
    append_nxt = append_r;
    bytes_nxt  = bytes_r;
    gaddr_nxt  = '0;
    status_nxt = fffa_pkg::ST_OK;
    wr.en      = 1'b0;
    wr.off     = append_r;
    wr.len     = size_r;
    if (state_r == S_UPD) begin
      if (early_r) begin
        status_nxt = fffa_pkg::ST_NULL;
      end else if (mode_r == fffa_pkg::MODE_ALLOC) begin
        if (res_tok_r.found) begin
          // reused fragment is charged at its full length
          bytes_nxt = bytes_r + res_tok_r.len;
          gaddr_nxt = res_tok_r.addr;
        end else if ((count_r == CW'(MAX_FRAGMENTS)) || !fits_pool) begin
          status_nxt = fffa_pkg::ST_NOSPACE;
        end else begin
          // append a fresh fragment of exactly the requested size
          wr.en      = 1'b1;
          count_nxt  = count_r + CW'(1);
          append_nxt = append_end[DW-1:0];
          bytes_nxt  = bytes_r + size_r;
          gaddr_nxt  = (base_r + append_r) & ADDR_MASK;
        end
      end else begin
        if (res_tok_r.found && res_tok_r.busy) begin
          bytes_nxt = (bytes_r > res_tok_r.len) ? (bytes_r - res_tok_r.len) : '0;
        end else begin
          // unknown start address or already released
          status_nxt = fffa_pkg::ST_NOTFOUND;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = req_bad ? S_UPD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      count_r     <= '0;
      append_r    <= '0;
      bytes_r     <= '0;
      base_r      <= fffa_pkg::BASE_ADDRESS_RST;
      pool_r      <= fffa_pkg::POOL_SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_acc && !req_bad;
      count_r  <= count_nxt;
      append_r <= append_nxt;
      bytes_r  <= bytes_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index == fffa_pkg::REG_BASE_ADDRESS) begin
          base_r <= cfg_chan.wdata;
        end else if (cfg_chan.index == fffa_pkg::REG_POOL_SIZE) begin
          pool_r <= cfg_chan.wdata;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request payload and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_chan.mode;
      size_r  <= in_chan.request_size;
      addr_r  <= in_chan.address;
      early_r <= req_bad;
    end
    if (in_acc) begin
      res_tok_r <= '0;
    end else if (scan_done) begin
      res_tok_r <= tok_w[MAX_FRAGMENTS];
    end
    if (state_r == S_UPD) begin
      gaddr_r  <= gaddr_nxt;
      status_r <= status_nxt;
    end
    if (out_load) begin
      out_gaddr_r  <= gaddr_r;
      out_status_r <= status_r;
      out_used_r   <= bytes_r;
      out_free_r   <= (pool_r > bytes_r) ? (pool_r - bytes_r) : '0;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.granted_address = out_gaddr_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.used_bytes      = out_used_r;
  assign out_chan.free_bytes      = out_free_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a token only reaches the end of the row while a scan is running
  `FFFA_ASSERT_IMP(a_token_in_scan, clk, rst_n, scan_done, state_r == S_SCAN)
  // a taken request starts either a scan or a direct update
  `FFFA_ASSERT_NXT(a_accept_moves, clk, rst_n, in_acc, state_r == S_SCAN || state_r == S_UPD)
  // the fill count never passes the table depth
  `FFFA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(MAX_FRAGMENTS))
  // an append only happens with room left in the table
  `FFFA_ASSERT_IMP(a_append_room, clk, rst_n, wr.en, count_r < CW'(MAX_FRAGMENTS))

endmodule
